/* rtl/slcg_pkg.sv */
package slcg_pkg;

  localparam int unsigned VALUE_W = 31;
  localparam int unsigned STATE_W = 32;
  localparam int unsigned MUL_W   = 15;
  localparam int unsigned PROD_W  = STATE_W + MUL_W;

  localparam logic [MUL_W-1:0]   LCG_MUL = MUL_W'(16807);
  localparam logic [VALUE_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
  localparam logic [VALUE_W-1:0] DEV_MAX = VALUE_W'(2147483389);

  localparam int unsigned WARM_EXTRA = 8;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

/* rtl/slcg_step.sv */
module slcg_step (
  input  logic                          clk_i,
  input  logic [slcg_pkg::STATE_W-1:0]  x_i,
  output slcg_pkg::value_t              y_o
);

  localparam int unsigned HI_W = slcg_pkg::PROD_W - slcg_pkg::VALUE_W;

  logic [slcg_pkg::PROD_W-1:0]  prod_q;
  logic [slcg_pkg::STATE_W-1:0] sum;
  logic [slcg_pkg::STATE_W-1:0] red;

  always_ff @(posedge clk_i) begin
    prod_q <= {{slcg_pkg::MUL_W{1'b0}}, x_i} *
              {{slcg_pkg::STATE_W{1'b0}}, slcg_pkg::LCG_MUL};
  end

  // 2^31 is 1 modulo 2^31-1, so fold the high part onto the low part
  always_comb begin
    sum = {1'b0, prod_q[slcg_pkg::VALUE_W-1:0]} +
          {{(slcg_pkg::STATE_W - HI_W){1'b0}}, prod_q[slcg_pkg::PROD_W-1:slcg_pkg::VALUE_W]};
    if (sum >= {1'b0, slcg_pkg::LCG_MOD}) begin
      red = sum - {1'b0, slcg_pkg::LCG_MOD};
    end else begin
      red = sum;
    end
  end

  assign y_o = red[slcg_pkg::VALUE_W-1:0];

endmodule

/* rtl/shuffled_lcg_random_generator_top.sv */
// a draw steps through the multiply, reduce, index and output states after the request,
// holding in the output state until the output register is free; no new request is taken
// before then. A draw after a non-positive seed write, or before the table is filled,
// first runs TableEntries+8 generator steps; 16807 multiply and table read are registered
// reset: generator state -1, previous pick 0 (table empty), no result pending;
// the shuffle table is not cleared, the first draw always refills it
module shuffled_lcg_random_generator_top #(
  parameter int unsigned TableEntries = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,   // seed_value
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [0] draw_request, [7:1] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // [30:0] deviate, [31] zero
);

  localparam int unsigned IW = $clog2(TableEntries);
  localparam int unsigned QW = IW + 1;
  localparam int unsigned CW = $clog2(TableEntries + slcg_pkg::WARM_EXTRA);
  localparam int unsigned PW = slcg_pkg::VALUE_W + QW;
  localparam int unsigned MW = slcg_pkg::VALUE_W + 2;
  localparam longint unsigned Bucket = 1 + (2147483647 - 1) / TableEntries;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WMUL = 3'd1;
  localparam logic [2:0] ST_WRED = 3'd2;
  localparam logic [2:0] ST_DMUL = 3'd3;
  localparam logic [2:0] ST_DRED = 3'd4;
  localparam logic [2:0] ST_DIDX = 3'd5;
  localparam logic [2:0] ST_DOUT = 3'd6;

  logic [2:0]                   fsm_q, fsm_d;
  logic [slcg_pkg::STATE_W-1:0] state_q, state_d;
  slcg_pkg::value_t             pick_q, pick_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;
  slcg_pkg::value_t             out_data_q;
  logic [QW-1:0]                q0_q;
  logic [MW-1:0]                m_q;
  logic [IW-1:0]                idx_q;

  slcg_pkg::value_t             step_y;
  slcg_pkg::value_t             mem [TableEntries];
  slcg_pkg::value_t             rdata_q;

  logic                         wr_en;
  logic [IW-1:0]                wr_addr;
  slcg_pkg::value_t             wr_data;
  logic                         rd_en;
  logic [IW-1:0]                idx;
  logic [QW-1:0]                q;
  logic [PW-1:0]                pn;
  logic [MW-1:0]                pick_ext;
  logic                         accept;
  logic                         warm_needed;
  logic                         out_free;
  logic                         out_load;

  slcg_step u_step (
    .clk_i (clk_i),
    .x_i   (state_q),
    .y_o   (step_y)
  );

  assign accept      = s_axis_tvalid_i && s_axis_tready_o;
  assign warm_needed = ($signed(state_q) <= 0) || (pick_q == '0);
  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign out_load    = (fsm_q == ST_DOUT) && out_free;

  assign pn       = {{QW{1'b0}}, pick_q} * PW'(TableEntries);
  assign pick_ext = {2'b00, pick_q};

  // quotient estimate is off by at most one, correct it against the bucket size
  always_comb begin
    if (m_q > pick_ext) begin
      q = q0_q - QW'(1);
    end else if (m_q + MW'(Bucket) <= pick_ext) begin
      q = q0_q + QW'(1);
    end else begin
      q = q0_q;
    end
    if (q >= QW'(TableEntries)) begin
      idx = IW'(TableEntries - 1);
    end else begin
      idx = q[IW-1:0];
    end
  end

  always_comb begin
    fsm_d       = fsm_q;
    state_d     = state_q;
    pick_d      = pick_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = state_q[slcg_pkg::VALUE_W-1:0];
    rd_en       = 1'b0;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (fsm_q)
      ST_IDLE: begin
        if (accept && s_axis_tdata_i[0]) begin
          if (warm_needed) begin
            if ($signed(state_q) < 0) begin
              state_d = -state_q;
            end else begin
              state_d = slcg_pkg::STATE_W'(1);
            end
            cnt_d = CW'(TableEntries + slcg_pkg::WARM_EXTRA - 1);
            fsm_d = ST_WMUL;
          end else begin
            fsm_d = ST_DMUL;
          end
        end
      end
      ST_WMUL: begin
        fsm_d = ST_WRED;
      end
      ST_WRED: begin
        state_d = {1'b0, step_y};
        if (cnt_q < CW'(TableEntries)) begin
          wr_en   = 1'b1;
          wr_addr = cnt_q[IW-1:0];
          wr_data = step_y;
        end
        if (cnt_q == '0) begin
          pick_d = step_y;
          fsm_d  = ST_DMUL;
        end else begin
          cnt_d = cnt_q - CW'(1);
          fsm_d = ST_WMUL;
        end
      end
      ST_DMUL: begin
        fsm_d = ST_DRED;
      end
      ST_DRED: begin
        state_d = {1'b0, step_y};
        fsm_d   = ST_DIDX;
      end
      ST_DIDX: begin
        rd_en = 1'b1;
        fsm_d = ST_DOUT;
      end
      ST_DOUT: begin
        if (out_free) begin
          wr_en       = 1'b1;
          pick_d      = rdata_q;
          out_valid_d = 1'b1;
          fsm_d       = ST_IDLE;
        end
      end
      default: begin
        fsm_d = ST_IDLE;
      end
    endcase

    if (cfg_wr_en_i) begin
      state_d = cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_IDLE;
      state_q     <= '1;
      pick_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      state_q     <= state_d;
      pick_q      <= pick_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fsm_q == ST_DMUL) begin
      q0_q <= pn[slcg_pkg::VALUE_W +: QW];
    end
    if (fsm_q == ST_DRED) begin
      m_q <= {{(MW - QW){1'b0}}, q0_q} * MW'(Bucket);
    end
    if (rd_en) begin
      idx_q <= idx;
    end
    if (out_load) begin
      if (rdata_q > slcg_pkg::DEV_MAX) begin
        out_data_q <= slcg_pkg::DEV_MAX;
      end else begin
        out_data_q <= rdata_q;
      end
    end
  end

  // shuffle table
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[idx];
    end
  end

  assign s_axis_tready_o = (fsm_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_data_q};

endmodule
